// ===== sv/prp_dma_segment_builder_macros.svh =====
// Assertion macros shared by the segment builder RTL.
// Needs signals named clock and reset in the scope of each use.
`ifndef PRP_DMA_SEGMENT_BUILDER_MACROS_SVH
`define PRP_DMA_SEGMENT_BUILDER_MACROS_SVH

// cond must hold at every clock edge outside reset
`define PRP_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define PRP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define PRP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/prp_seg_pkg.sv =====
// Shared types and constants of the PRP segment builder.
// No dependencies; used by prp_seg_take, prp_seg_fifo and the top level.
package prp_seg_pkg;

   localparam int PAGE_BYTES_DEF = 4096;
   localparam int LIST_ENTRIES   = 512;
   // chained lists are not followed, so one list's entries cap the fetch, within the count field
   localparam int LIST_CAP       = (LIST_ENTRIES > 1023) ? 1023 : LIST_ENTRIES;

   localparam int ADDR_W = 64;
   localparam int OFF_W  = 48;
   localparam int LEN_W  = 22;
   localparam int CNT_W  = 10;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

   typedef enum logic {
      ACT_BEGIN = 1'b0,
      ACT_ENTRY = 1'b1
   } action_type;

   typedef enum logic {
      KIND_FETCH   = 1'b0,
      KIND_SEGMENT = 1'b1
   } kind_type;

   // one output word; offset is the running storage offset, base added at the port
   typedef struct packed {
      kind_type              kind;
      logic [ADDR_W-1:0]     host;
      logic [OFF_W-1:0]      offset;
      logic [LEN_W-1:0]      bytes;
      logic [CNT_W-1:0]      count;
      logic                  dir;
      logic                  last;
   } word_type;

   // one page taken against the segment under construction
   typedef struct packed {
      logic [ADDR_W-1:0] page;
      logic [ADDR_W-1:0] pend_start;
      logic [LEN_W-1:0]  pend_bytes;
      logic [ADDR_W-1:0] prev_page;
      logic [LEN_W-1:0]  bytes_left;
   } take_in_type;

   typedef struct packed {
      logic              flush;      // old segment closes, not last
      logic [ADDR_W-1:0] new_start;
      logic [LEN_W-1:0]  new_bytes;
      logic [LEN_W-1:0]  bytes_left;
      logic              done;       // no bytes left: segment closes as last
   } take_out_type;

endpackage

// ===== sv/prp_seg_take.sv =====
// One page step: cut at page offset and remaining bytes, merge or split.
// Depends on prp_seg_pkg.
module prp_seg_take #(
   parameter int PAGE_BYTES = prp_seg_pkg::PAGE_BYTES_DEF
) (
   input  prp_seg_pkg::take_in_type  take_i,
   output prp_seg_pkg::take_out_type take_o
);
   import prp_seg_pkg::*;

   localparam int PAGE_LOG2 = $clog2(PAGE_BYTES);
   localparam int SPAN_W    = PAGE_LOG2 + 1;

   logic [SPAN_W-1:0] span;
   logic [LEN_W-1:0]  span_len;
   logic [LEN_W-1:0]  take_len;
   logic              merge;

   assign span     = SPAN_W'(PAGE_BYTES) - {1'b0, take_i.page[PAGE_LOG2-1:0]};
   assign span_len = LEN_W'(span);
   assign take_len = (span_len > take_i.bytes_left) ? take_i.bytes_left : span_len;

   // contiguous with the previous page: grow the open segment
   assign merge = (take_i.pend_bytes != '0) &&
                  (take_i.page == take_i.prev_page + ADDR_W'(PAGE_BYTES));

   always_comb begin
      take_o.flush      = (take_i.pend_bytes != '0) && !merge;
      take_o.new_start  = merge ? take_i.pend_start : take_i.page;
      take_o.new_bytes  = merge ? (take_i.pend_bytes + take_len) : take_len;
      take_o.bytes_left = take_i.bytes_left - take_len;
      take_o.done       = (take_i.bytes_left == take_len);
   end

endmodule

// ===== sv/prp_seg_fifo.sv =====
// Small result queue: up to two words in per cycle, one word out while out_stall is low.
// Depends on prp_seg_pkg and the assertion macro header.
module prp_seg_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_n,
   input  prp_seg_pkg::word_type push_w0,
   input  prp_seg_pkg::word_type push_w1,
   output logic                  in_stall,
   output logic                  out_valid,
   input  logic                  out_stall,
   output prp_seg_pkg::word_type out_word
);
   import prp_seg_pkg::*;
`include "prp_dma_segment_builder_macros.svh"

   word_type          mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FCNT_W-1:0] count_ff, count_in;
   logic              pop;

   assign out_valid = (count_ff != '0);
   assign out_word  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;
   // keep room for the largest burst of one item
   assign in_stall  = (count_ff > FCNT_W'(FIFO_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + FCNT_W'(push_n) - FCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_w0;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push_w1;
      end
   end

   `PRP_ASSERT_IMPLY(a_no_overflow, push_n != 2'd0, (FCNT_W+1)'(count_ff) + (FCNT_W+1)'(push_n) <= (FCNT_W+1)'(FIFO_DEPTH), "result queue overflow")
   `PRP_ASSERT_ALWAYS(a_count_bound, count_ff <= FCNT_W'(FIFO_DEPTH), "result queue count out of range")
   `PRP_ASSERT_NEXT(a_empty_stays, count_ff == '0 && push_n == 2'd0, !out_valid, "word appeared without a push")

endmodule

// ===== sv/prp_dma_segment_builder.sv =====
// Top level of the PRP to DMA segment builder.
// Depends on prp_seg_pkg, prp_seg_take, prp_seg_fifo and the macro header.
//
// Use:
//   req_* carries one word per accepted item: a begin command (direction,
//   length, storage offset, PRP1, PRP2) or one PRP list entry.
//   rsp_* returns fetch requests for the PRP list and DMA copy segments;
//   the final segment of a command has rsp_last set.
//   csr_wr_en/csr_wr_data load the storage base; write it only while idle.
// Timing:
//   One item is accepted per cycle while req_stall is low. Its words show
//   on rsp_* once the words queued ahead of them have left. An item yields
//   zero, one or two words; the output drains one word per cycle while
//   rsp_stall is low. A four-word result queue sits between the two sides
//   and req_stall rises while more than two words are held.
// Reset:
//   Synchronous, active high. Clears the queue, busy flag, list entry count
//   and storage base. A begin item drops any command still in progress.
// Stall:
//   While rsp_stall is high the head word holds; the queue keeps taking
//   items until it can no longer fit a two-word burst.
module prp_dma_segment_builder #(
   parameter int PAGE_BYTES = prp_seg_pkg::PAGE_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_wr_en,
   input  logic [prp_seg_pkg::OFF_W-1:0]     csr_wr_data,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic                              req_to_device,
   input  logic [prp_seg_pkg::LEN_W-1:0]     req_length_bytes,
   input  logic [prp_seg_pkg::OFF_W-1:0]     req_storage_offset,
   input  logic [prp_seg_pkg::ADDR_W-1:0]    req_prp_first,
   input  logic [prp_seg_pkg::ADDR_W-1:0]    req_prp_second,
   input  logic [prp_seg_pkg::ADDR_W-1:0]    req_list_entry,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_kind,
   output logic [prp_seg_pkg::ADDR_W-1:0]    rsp_host_addr,
   output logic [prp_seg_pkg::OFF_W-1:0]     rsp_device_addr,
   output logic [prp_seg_pkg::LEN_W-1:0]     rsp_seg_bytes,
   output logic [prp_seg_pkg::CNT_W-1:0]     rsp_list_count,
   output logic                              rsp_write_dir,
   output logic                              rsp_last
);
   import prp_seg_pkg::*;
`include "prp_dma_segment_builder_macros.svh"

   localparam int PAGE_LOG2 = $clog2(PAGE_BYTES);

   // configuration and command state
   logic [OFF_W-1:0]  storage_base_ff;
   logic              busy_ff, busy_in;
   logic              direction_ff, direction_in;
   logic [LEN_W-1:0]  bytes_left_ff, bytes_left_in;
   logic [OFF_W-1:0]  running_offset_ff, running_offset_in;
   logic [ADDR_W-1:0] pending_start_ff, pending_start_in;
   logic [LEN_W-1:0]  pending_bytes_ff, pending_bytes_in;
   logic [ADDR_W-1:0] previous_entry_ff, previous_entry_in;
   logic [CNT_W-1:0]  entries_left_ff, entries_left_in;

   logic              accept;
   logic              is_begin;
   take_in_type       first_in, step_in;
   take_out_type      first_out, step_out;
   logic [OFF_W-1:0]  offset_base;
   logic [OFF_W-1:0]  offset_after;
   logic [LEN_W:0]    need_sum;
   logic [LEN_W:0]    need_raw;
   logic [CNT_W-1:0]  need;
   logic [CNT_W-1:0]  entries_dec;
   logic              cmd_dir;
   word_type          flush_word, final_word;
   word_type          push_w0, push_w1;
   logic [1:0]        push_n;
   logic              fifo_stall;
   word_type          head;

   assign accept   = req_valid && !req_stall;
   assign is_begin = (req_action == ACT_BEGIN);
   assign cmd_dir  = is_begin ? req_to_device : direction_ff;

   // PRP1 always opens a fresh segment
   always_comb begin
      first_in.page       = req_prp_first;
      first_in.pend_start = '0;
      first_in.pend_bytes = '0;
      first_in.prev_page  = '0;
      first_in.bytes_left = req_length_bytes;
   end

   prp_seg_take #(.PAGE_BYTES(PAGE_BYTES)) u_take_first (
      .take_i (first_in),
      .take_o (first_out)
   );

   // shared step: PRP2 for a two-page begin, or the arriving list entry
   always_comb begin
      if (is_begin) begin
         step_in.page       = req_prp_second;
         step_in.pend_start = req_prp_first;
         step_in.pend_bytes = first_out.new_bytes;
         step_in.prev_page  = req_prp_first;
         step_in.bytes_left = first_out.bytes_left;
      end else begin
         step_in.page       = req_list_entry;
         step_in.pend_start = pending_start_ff;
         step_in.pend_bytes = pending_bytes_ff;
         step_in.prev_page  = previous_entry_ff;
         step_in.bytes_left = bytes_left_ff;
      end
   end

   prp_seg_take #(.PAGE_BYTES(PAGE_BYTES)) u_take_step (
      .take_i (step_in),
      .take_o (step_out)
   );

   // storage offset moves on only when a segment closes
   assign offset_base  = is_begin ? req_storage_offset : running_offset_ff;
   assign offset_after = step_out.flush ? (offset_base + OFF_W'(step_in.pend_bytes))
                                        : offset_base;

   // list entries to fetch: pages still needed, capped
   assign need_sum    = {1'b0, first_out.bytes_left} + (LEN_W+1)'(PAGE_BYTES - 1);
   assign need_raw    = need_sum >> PAGE_LOG2;
   assign need        = (need_raw > (LEN_W+1)'(LIST_CAP)) ? CNT_W'(LIST_CAP)
                                                          : need_raw[CNT_W-1:0];
   assign entries_dec = entries_left_ff - CNT_W'(entries_left_ff != '0);

   always_comb begin
      flush_word.kind   = KIND_SEGMENT;
      flush_word.host   = step_in.pend_start;
      flush_word.offset = offset_base;
      flush_word.bytes  = step_in.pend_bytes;
      flush_word.count  = '0;
      flush_word.dir    = cmd_dir;
      flush_word.last   = 1'b0;

      final_word.kind   = KIND_SEGMENT;
      final_word.host   = step_out.new_start;
      final_word.offset = offset_after;
      final_word.bytes  = step_out.new_bytes;
      final_word.count  = '0;
      final_word.dir    = cmd_dir;
      final_word.last   = 1'b1;
   end

   always_comb begin
      busy_in           = busy_ff;
      direction_in      = direction_ff;
      bytes_left_in     = bytes_left_ff;
      running_offset_in = running_offset_ff;
      pending_start_in  = pending_start_ff;
      pending_bytes_in  = pending_bytes_ff;
      previous_entry_in = previous_entry_ff;
      entries_left_in   = entries_left_ff;
      push_n            = 2'd0;
      push_w0           = flush_word;
      push_w1           = final_word;

      if (accept && is_begin) begin
         busy_in           = 1'b0;
         entries_left_in   = '0;
         direction_in      = req_to_device;
         bytes_left_in     = req_length_bytes;
         running_offset_in = req_storage_offset;
         pending_start_in  = '0;
         pending_bytes_in  = '0;
         if (req_length_bytes == '0) begin
            // zero length: nothing to move
         end else if (first_out.done) begin
            // all bytes inside the first page
            push_n            = 2'd1;
            push_w0           = final_word;
            push_w0.host      = req_prp_first;
            push_w0.offset    = req_storage_offset;
            push_w0.bytes     = first_out.new_bytes;
            previous_entry_in = req_prp_first;
            bytes_left_in     = '0;
         end else if (first_out.bytes_left <= LEN_W'(PAGE_BYTES)) begin
            // PRP2 is the second data page
            previous_entry_in = req_prp_second;
            bytes_left_in     = step_out.bytes_left;
            running_offset_in = offset_after;
            pending_start_in  = step_out.new_start;
            pending_bytes_in  = step_out.done ? '0 : step_out.new_bytes;
            push_n            = 2'(step_out.flush) + 2'(step_out.done);
            if (!step_out.flush) begin
               push_w0 = final_word;
            end
         end else begin
            // PRP2 points at a list: ask for it and wait
            push_n            = 2'd1;
            push_w0.kind      = KIND_FETCH;
            push_w0.host      = req_prp_second;
            push_w0.offset    = '0;
            push_w0.bytes     = '0;
            push_w0.count     = need;
            push_w0.dir       = req_to_device;
            push_w0.last      = 1'b0;
            busy_in           = 1'b1;
            entries_left_in   = need;
            pending_start_in  = req_prp_first;
            pending_bytes_in  = first_out.new_bytes;
            previous_entry_in = req_prp_first;
            bytes_left_in     = first_out.bytes_left;
         end
      end else if (accept && busy_ff) begin
         // list entry; entries while idle fall through untouched
         previous_entry_in = req_list_entry;
         bytes_left_in     = step_out.bytes_left;
         running_offset_in = offset_after;
         pending_start_in  = step_out.new_start;
         pending_bytes_in  = step_out.new_bytes;
         entries_left_in   = entries_dec;
         if (step_out.done || entries_dec == '0) begin
            // out of bytes, or a short list: close as last
            push_n           = 2'(step_out.flush) + 2'd1;
            busy_in          = 1'b0;
            entries_left_in  = '0;
            bytes_left_in    = '0;
            pending_bytes_in = '0;
         end else begin
            push_n = 2'(step_out.flush);
         end
         if (!step_out.flush) begin
            push_w0 = final_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         storage_base_ff <= '0;
         busy_ff         <= 1'b0;
         entries_left_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            storage_base_ff <= csr_wr_data;
         end
         busy_ff         <= busy_in;
         entries_left_ff <= entries_left_in;
      end
   end

   always_ff @(posedge clock) begin
      direction_ff      <= direction_in;
      bytes_left_ff     <= bytes_left_in;
      running_offset_ff <= running_offset_in;
      pending_start_ff  <= pending_start_in;
      pending_bytes_ff  <= pending_bytes_in;
      previous_entry_ff <= previous_entry_in;
   end

   prp_seg_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push_w0   (push_w0),
      .push_w1   (push_w1),
      .in_stall  (fifo_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (head)
   );

   assign req_stall = fifo_stall;

   // base is added at the port; the user must keep it static while words are in flight, the block does not check
   assign rsp_kind        = head.kind;
   assign rsp_host_addr   = head.host;
   assign rsp_device_addr = (head.kind == KIND_SEGMENT) ? (storage_base_ff + head.offset)
                                                        : '0;
   assign rsp_seg_bytes   = head.bytes;
   assign rsp_list_count  = head.count;
   assign rsp_write_dir   = head.dir;
   assign rsp_last        = head.last;

   `PRP_ASSERT_IMPLY(a_busy_expects_entries, busy_ff, entries_left_ff != '0,
                     "busy with no list entries expected")
   `PRP_ASSERT_IMPLY(a_idle_entry_silent, accept && req_action == ACT_ENTRY && !busy_ff,
                     push_n == 2'd0, "entry while idle produced a word")
   `PRP_ASSERT_IMPLY(a_fetch_shape, rsp_valid && rsp_kind == KIND_FETCH,
                     !rsp_last && rsp_seg_bytes == '0, "malformed list fetch word")

endmodule
